[sv/rar_pkg.sv]
// Package for the rational arithmetic and reduction block.
// Holds operation codes, result widths and default sizes; depends on nothing.
`default_nettype none
package rar_pkg;

  localparam int OPERAND_WIDTH_DEF = 32;
  localparam int RES_W = 64;
  localparam int CNT_W = 6;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_t;

  typedef enum logic [9:0] {
    ST_IDLE = 10'b00_0000_0001,
    ST_M0   = 10'b00_0000_0010,
    ST_M1   = 10'b00_0000_0100,
    ST_M2   = 10'b00_0000_1000,
    ST_M3   = 10'b00_0001_0000,
    ST_MAG  = 10'b00_0010_0000,
    ST_GCD  = 10'b00_0100_0000,
    ST_DIVN = 10'b00_1000_0000,
    ST_DIVD = 10'b01_0000_0000,
    ST_FIN  = 10'b10_0000_0000
  } state_t;

endpackage
`default_nettype wire

[sv/rational_arith_reduce.sv]
// Rational add, subtract, multiply and divide with reduction to lowest terms.
// Steps: products in states M0 to M2, plus M3 for add and subtract, then
// binary GCD steps, restoring division of numerator then denominator by the
// GCD, and a load of the output register. One transaction at a time, with a
// zero part skipping GCD and division; the GCD loop and divisions share one
// 64-bit subtractor. Synchronous active-low reset.
`default_nettype none
module rational_arith_reduce #(
  parameter int OPERAND_WIDTH = rar_pkg::OPERAND_WIDTH_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [1:0]                      in_mode,
  input  wire logic signed [OPERAND_WIDTH-1:0] in_a_num,
  input  wire logic [OPERAND_WIDTH-2:0]        in_a_den,
  input  wire logic signed [OPERAND_WIDTH-1:0] in_b_num,
  input  wire logic [OPERAND_WIDTH-2:0]        in_b_den,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic signed [rar_pkg::RES_W-1:0]     out_res_num,
  output logic [rar_pkg::RES_W-2:0]            out_res_den,
  output logic                                 out_zero_divisor
);
  import rar_pkg::*;

  localparam int W = OPERAND_WIDTH;

  state_t state_r, state_nxt;

  // Captured operands of the transaction in progress.
  op_t                 mode_r;
  logic signed [W-1:0] an_r, bn_r;
  logic [W-2:0]        ad_r, bd_r;

  // Working registers: numerator, denominator, GCD pair, remainder, counters.
  logic [RES_W-1:0]   n_r, d_r, u_r, v_r, rem_r, prod_r;
  logic [CNT_W-1:0]   k_r, cnt_r;
  logic               neg_r, flag_r;
  logic               out_valid_r;
  logic [RES_W-1:0]   res_num_r;
  logic [RES_W-2:0]   res_den_r;
  logic               res_flag_r;

  // Shared multiplier, one product per cycle, registered in prod_r.
  logic signed [W:0]     an_x, bn_x, ad_x, bd_x, ma, mb;
  logic signed [2*W+1:0] prod;

  assign an_x = {an_r[W-1], an_r};
  assign bn_x = {bn_r[W-1], bn_r};
  assign ad_x = {2'b00, ad_r};
  assign bd_x = {2'b00, bd_r};

  always_comb begin
    ma = ad_x;
    mb = bd_x;
    if (state_r == ST_M0) begin
      ma = an_x;
      mb = (mode_r == OP_MUL) ? bn_x : bd_x;
    end else if (state_r == ST_M1) begin
      unique case (mode_r)
        OP_ADD, OP_SUB: begin ma = bn_x; mb = ad_x; end
        OP_MUL:         begin ma = ad_x; mb = bd_x; end
        OP_DIV:         begin ma = ad_x; mb = bn_x; end
        default:        begin ma = ad_x; mb = bd_x; end
      endcase
    end
  end

  assign prod = ma * mb;

  // Shared subtractor: GCD compare-subtract or one restoring division step.
  logic [RES_W-1:0] sub_a, shift_t;
  logic [RES_W:0]   diff;
  logic             borrow;
  logic [RES_W-1:0] q_nxt;

  assign shift_t = {rem_r[RES_W-2:0], u_r[RES_W-1]};
  assign sub_a   = (state_r == ST_GCD) ? u_r : shift_t;
  assign diff    = {1'b0, sub_a} - {1'b0, v_r};
  assign borrow  = diff[RES_W];
  assign q_nxt   = {u_r[RES_W-2:0], ~borrow};

  logic [RES_W-1:0] n_mag, d_mag;
  assign n_mag = n_r[RES_W-1] ? (RES_W'(0) - n_r) : n_r;
  assign d_mag = d_r[RES_W-1] ? (RES_W'(0) - d_r) : d_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_valid) state_nxt = ST_M0;
      ST_M0:   state_nxt = ST_M1;
      ST_M1:   state_nxt = ST_M2;
      ST_M2:   state_nxt = (mode_r == OP_ADD || mode_r == OP_SUB) ? ST_M3 : ST_MAG;
      ST_M3:   state_nxt = ST_MAG;
      ST_MAG: begin
        if (d_r == '0 || n_r == '0) state_nxt = ST_FIN;
        else state_nxt = ST_GCD;
      end
      ST_GCD:  if (u_r == '0) state_nxt = ST_DIVN;
      ST_DIVN: if (cnt_r == '1) state_nxt = ST_DIVD;
      ST_DIVD: if (cnt_r == '1) state_nxt = ST_FIN;
      ST_FIN:  if (!out_valid_r || !out_stall) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_FIN && (!out_valid_r || !out_stall)) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= RES_W'(prod);
    unique case (state_r)
      ST_IDLE: begin
        mode_r <= op_t'(in_mode);
        an_r   <= in_a_num;
        ad_r   <= in_a_den;
        bn_r   <= in_b_num;
        bd_r   <= in_b_den;
      end
      ST_M1: n_r <= prod_r;
      ST_M2: begin
        if (mode_r == OP_ADD) n_r <= n_r + prod_r;
        else if (mode_r == OP_SUB) n_r <= n_r - prod_r;
        else d_r <= prod_r;
      end
      ST_M3: d_r <= prod_r;
      ST_MAG: begin
        // Signs are split off here; the sign of the result is kept aside.
        n_r    <= n_mag;
        flag_r <= (d_r == '0);
        if (d_r == '0) begin
          neg_r <= n_r[RES_W-1];
          d_r   <= RES_W'(1);
        end else if (n_r == '0) begin
          neg_r <= 1'b0;
          d_r   <= RES_W'(1);
        end else begin
          neg_r <= n_r[RES_W-1] ^ d_r[RES_W-1];
          d_r   <= d_mag;
        end
        u_r <= n_mag;
        v_r <= d_mag;
        k_r <= '0;
      end
      ST_GCD: begin
        // Binary GCD: strip common twos, then subtract odd from odd.
        if (u_r == '0) begin
          v_r   <= v_r << k_r;
          u_r   <= n_r;
          rem_r <= '0;
          cnt_r <= '0;
        end else if (!u_r[0] && !v_r[0]) begin
          u_r <= u_r >> 1;
          v_r <= v_r >> 1;
          k_r <= k_r + 1'b1;
        end else if (!u_r[0]) begin
          u_r <= u_r >> 1;
        end else if (!v_r[0]) begin
          v_r <= v_r >> 1;
        end else if (borrow) begin
          u_r <= v_r;
          v_r <= u_r;
        end else begin
          u_r <= diff[RES_W:1];
        end
      end
      ST_DIVN, ST_DIVD: begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == '1) begin
          rem_r <= '0;
          if (state_r == ST_DIVN) begin
            n_r <= q_nxt;
            u_r <= d_r;
          end else begin
            d_r <= q_nxt;
            u_r <= q_nxt;
          end
        end else begin
          rem_r <= borrow ? shift_t : diff[RES_W-1:0];
          u_r   <= q_nxt;
        end
      end
      ST_FIN: begin
        if (!out_valid_r || !out_stall) begin
          res_num_r  <= neg_r ? (RES_W'(0) - n_r) : n_r;
          res_den_r  <= d_r[RES_W-2:0];
          res_flag_r <= flag_r;
        end
      end
      default: ;
    endcase
  end

  assign in_stall         = (state_r != ST_IDLE);
  assign out_valid        = out_valid_r;
  assign out_res_num      = res_num_r;
  assign out_res_den      = res_den_r;
  assign out_zero_divisor = res_flag_r;

endmodule
`default_nettype wire
